@@ hdl/mepc_pkg.sv @@
// Shared constants and types for the mesh edge pairing check.
// Used by the top level, mepc_front, mepc_back and the port checks; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mepc_pkg;

  localparam int VERTEX_BITS_DEF   = 16;
  localparam int EDGE_CAPACITY_DEF = 1024;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_TWICE = 3'd2;
  localparam logic [2:0] ST_LONER = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WSCAN,
    B_PSCAN,
    B_MVRD,
    B_MVWR,
    B_FIN
  } back_state_t;

  typedef struct packed {
    logic valid;
    logic last;
  } queue_ctl_t;

endpackage
`default_nettype wire

@@ hdl/mesh_edge_pairing_check.sv @@
// Mesh edge pairing check: per-triangle check that a mesh is closed and
// consistently oriented. Each edge is sought by a linear scan of the waiting
// edge table and, for an edge that pairs, of the paired edge table; these
// linear scans set the rate. A triangle after a failure skips the scans.
// Reset empties both tables at once (counts cleared).
// Depends on mepc_pkg, mepc_front, mepc_back.
`timescale 1ns / 1ps
`default_nettype none
module mesh_edge_pairing_check #(
  parameter int VERTEX_BITS   = mepc_pkg::VERTEX_BITS_DEF,
  parameter int EDGE_CAPACITY = mepc_pkg::EDGE_CAPACITY_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   tri_valid,
  output logic                        tri_stall,
  input  wire logic [VERTEX_BITS-1:0] vertex_a,
  input  wire logic [VERTEX_BITS-1:0] vertex_b,
  input  wire logic [VERTEX_BITS-1:0] vertex_c,
  input  wire logic                   last_triangle,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output logic      [2:0]             status,
  output logic                        mesh_done,
  output logic                        mesh_valid
);
  import mepc_pkg::*;

  queue_ctl_t             q_ctl;
  logic [VERTEX_BITS-1:0] q_a, q_b, q_c;
  logic                   q_pop;

  mepc_front #(.VERTEX_BITS(VERTEX_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .tri_valid     (tri_valid),
    .tri_stall     (tri_stall),
    .vertex_a      (vertex_a),
    .vertex_b      (vertex_b),
    .vertex_c      (vertex_c),
    .last_triangle (last_triangle),
    .q_ctl         (q_ctl),
    .q_a           (q_a),
    .q_b           (q_b),
    .q_c           (q_c),
    .q_pop         (q_pop)
  );

  mepc_back #(.VERTEX_BITS(VERTEX_BITS), .EDGE_CAPACITY(EDGE_CAPACITY)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_ctl      (q_ctl),
    .q_a        (q_a),
    .q_b        (q_b),
    .q_c        (q_c),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .mesh_done  (mesh_done),
    .mesh_valid (mesh_valid)
  );

endmodule
`default_nettype wire

@@ hdl/mepc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module mepc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/mepc_front.sv @@
// Front end: accepts triangles and holds them in a two-entry queue.
// Depends on mepc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mepc_front #(
  parameter int VERTEX_BITS = mepc_pkg::VERTEX_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   tri_valid,
  output logic                        tri_stall,
  input  wire logic [VERTEX_BITS-1:0] vertex_a,
  input  wire logic [VERTEX_BITS-1:0] vertex_b,
  input  wire logic [VERTEX_BITS-1:0] vertex_c,
  input  wire logic                   last_triangle,
  output mepc_pkg::queue_ctl_t        q_ctl,
  output logic      [VERTEX_BITS-1:0] q_a,
  output logic      [VERTEX_BITS-1:0] q_b,
  output logic      [VERTEX_BITS-1:0] q_c,
  input  wire logic                   q_pop
);
  import mepc_pkg::*;

  logic [VERTEX_BITS-1:0] a_q [2];
  logic [VERTEX_BITS-1:0] b_q [2];
  logic [VERTEX_BITS-1:0] c_q [2];
  logic                   last_q [2];
  logic                   rd_ptr;
  logic                   wr_ptr;
  logic [1:0]             count;
  logic                   push;
  logic                   pop;

  assign tri_stall   = (count == 2'd2);
  assign push        = tri_valid && !tri_stall;
  assign pop         = q_pop && (count != 2'd0);
  assign q_ctl.valid = (count != 2'd0);
  assign q_ctl.last  = last_q[rd_ptr];
  assign q_a         = a_q[rd_ptr];
  assign q_b         = b_q[rd_ptr];
  assign q_c         = c_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      a_q[wr_ptr]    <= vertex_a;
      b_q[wr_ptr]    <= vertex_b;
      c_q[wr_ptr]    <= vertex_c;
      last_q[wr_ptr] <= last_triangle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/mepc_back.sv @@
// Back end: checks each edge of a triangle against the waiting and
// paired edge tables, and holds the result. Depends on mepc_pkg, mepc_ram.
`timescale 1ns / 1ps
`default_nettype none
module mepc_back #(
  parameter int VERTEX_BITS   = mepc_pkg::VERTEX_BITS_DEF,
  parameter int EDGE_CAPACITY = mepc_pkg::EDGE_CAPACITY_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  mepc_pkg::queue_ctl_t        q_ctl,
  input  wire logic [VERTEX_BITS-1:0] q_a,
  input  wire logic [VERTEX_BITS-1:0] q_b,
  input  wire logic [VERTEX_BITS-1:0] q_c,
  output logic                        q_pop,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output logic      [2:0]             status,
  output logic                        mesh_done,
  output logic                        mesh_valid
);
  import mepc_pkg::*;

  localparam int KW  = 2 * VERTEX_BITS;
  localparam int AW  = $clog2(EDGE_CAPACITY);
  localparam int CW  = $clog2(EDGE_CAPACITY + 1);
  localparam int PD  = EDGE_CAPACITY / 2;
  localparam int PAW = $clog2(PD);
  localparam int PCW = $clog2(PD + 1);

  back_state_t state, state_next;

  logic [1:0]     edge_idx;
  logic [CW-1:0]  idx;
  logic           pend;
  logic [AW-1:0]  pend_addr;
  logic           hit_key;
  logic           hit_rev;
  logic [AW-1:0]  rev_pos;
  logic [CW-1:0]  wcount;
  logic [PCW-1:0] pcount;
  logic           failed;
  logic [2:0]     st_code;

  logic [VERTEX_BITS-1:0] from_v, to_v;
  logic [KW-1:0]  key, rev;
  logic [CW-1:0]  scan_cnt, wlast;
  logic           issue, scan_done, last_edge, out_free, scan_start;
  logic           edge_ok, edge_fail;
  logic [2:0]     fail_code;
  logic           w_we, p_we;
  logic [AW-1:0]  w_waddr, w_raddr;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [KW-1:0]  w_wdata, w_rdata, p_rdata;
  logic           loners;

  always_comb begin
    case (edge_idx)
      2'd0:    begin from_v = q_a; to_v = q_b; end
      2'd1:    begin from_v = q_b; to_v = q_c; end
      default: begin from_v = q_c; to_v = q_a; end
    endcase
  end

  assign key       = {from_v, to_v};
  assign rev       = {to_v, from_v};
  assign scan_cnt  = (state == B_PSCAN) ? CW'(pcount) : wcount;
  assign issue     = (idx < scan_cnt);
  assign scan_done = !issue && !pend;
  assign last_edge = (edge_idx == 2'd2);
  assign out_free  = !res_valid || !res_stall;
  assign wlast     = wcount - CW'(1);
  assign loners    = !failed && (wcount != '0);
  assign q_pop     = (state == B_FIN) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_ctl.valid) begin
          state_next = failed ? B_FIN : B_WSCAN;
        end
      end
      B_WSCAN: begin
        if (edge_fail) begin
          state_next = B_FIN;
        end else if (edge_ok) begin
          state_next = last_edge ? B_FIN : B_WSCAN;
        end else if (scan_done) begin
          state_next = B_PSCAN;
        end
      end
      B_PSCAN: begin
        if (edge_fail) begin
          state_next = B_FIN;
        end else if (scan_done) begin
          state_next = B_MVRD;
        end
      end
      B_MVRD:  state_next = B_MVWR;
      B_MVWR:  state_next = last_edge ? B_FIN : B_WSCAN;
      B_FIN: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // table control
  always_comb begin
    w_we      = 1'b0;
    w_waddr   = wcount[AW-1:0];
    w_wdata   = key;
    w_raddr   = idx[AW-1:0];
    p_we      = 1'b0;
    p_waddr   = pcount[PAW-1:0];
    p_raddr   = idx[PAW-1:0];
    edge_ok   = 1'b0;
    edge_fail = 1'b0;
    fail_code = ST_OK;
    case (state)
      B_WSCAN: begin
        if (scan_done) begin
          if (hit_key) begin
            edge_fail = 1'b1;
            fail_code = ST_DUP;
          end else if (!hit_rev) begin
            if (wcount >= CW'(EDGE_CAPACITY)) begin
              edge_fail = 1'b1;
              fail_code = ST_FULL;
            end else begin
              w_we    = 1'b1;
              edge_ok = 1'b1;
            end
          end
        end
      end
      B_PSCAN: begin
        if (scan_done) begin
          if (hit_key) begin
            edge_fail = 1'b1;
            fail_code = ST_TWICE;
          end else if (pcount >= PCW'(PD)) begin
            edge_fail = 1'b1;
            fail_code = ST_FULL;
          end else begin
            p_we = 1'b1;
          end
        end
      end
      B_MVRD: begin
        w_raddr = wlast[AW-1:0];
      end
      B_MVWR: begin
        w_we    = 1'b1;
        w_waddr = rev_pos;
        w_wdata = w_rdata;
        edge_ok = 1'b1;
      end
      default: begin
        w_we = 1'b0;
      end
    endcase
  end

  assign scan_start = ((state == B_IDLE) && (state_next == B_WSCAN)) ||
                      (edge_ok && !last_edge) ||
                      ((state == B_WSCAN) && (state_next == B_PSCAN));

  always_ff @(posedge clk) begin
    if (scan_start) begin
      idx     <= '0;
      pend    <= 1'b0;
      hit_key <= 1'b0;
      if (state_next == B_WSCAN) begin
        hit_rev <= 1'b0;
      end
    end else begin
      idx       <= idx + CW'(issue);
      pend      <= issue;
      pend_addr <= idx[AW-1:0];
      if (pend && (state == B_WSCAN)) begin
        if (w_rdata == key) begin
          hit_key <= 1'b1;
        end
        if (w_rdata == rev) begin
          hit_rev <= 1'b1;
          rev_pos <= pend_addr;
        end
      end
      if (pend && (state == B_PSCAN) && ((p_rdata == key) || (p_rdata == rev))) begin
        hit_key <= 1'b1;
      end
    end
    if (state == B_IDLE) begin
      edge_idx <= 2'd0;
    end else if (edge_ok && !last_edge) begin
      edge_idx <= edge_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status     <= (q_ctl.last && loners) ? ST_LONER : st_code;
      mesh_done  <= q_ctl.last;
      mesh_valid <= q_ctl.last && !failed && (wcount == '0);
    end
    if (state == B_IDLE) begin
      st_code <= ST_OK;
    end else if (edge_fail) begin
      st_code <= fail_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wcount    <= '0;
      pcount    <= '0;
      failed    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (q_pop && q_ctl.last) begin
        wcount <= '0;
        pcount <= '0;
        failed <= 1'b0;
      end else begin
        if (edge_fail) begin
          failed <= 1'b1;
        end
        if (w_we && (state == B_WSCAN)) begin
          wcount <= wcount + CW'(1);
        end else if (state == B_MVWR) begin
          wcount <= wlast;
        end
        if (p_we) begin
          pcount <= pcount + PCW'(1);
        end
      end
    end
  end

  mepc_ram #(.WIDTH(KW), .DEPTH(EDGE_CAPACITY)) u_wait_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mepc_ram #(.WIDTH(KW), .DEPTH(PD)) u_pair_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (key),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

endmodule
`default_nettype wire

@@ hdl/mepc_checker.sv @@
// Port-level checks on the mesh edge pairing check, bound to its top level.
// Depends on mepc_pkg and mesh_edge_pairing_check.
`timescale 1ns / 1ps
`default_nettype none
module mepc_port_checks (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic [2:0] status,
  input wire logic       mesh_done,
  input wire logic       mesh_valid
);
  import mepc_pkg::*;

  a_valid_needs_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && mesh_valid |-> mesh_done)
    else $error("mesh_valid without mesh_done");

  a_valid_means_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && mesh_valid |-> status == ST_OK)
    else $error("mesh_valid with failing status");

  a_loner_on_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_LONER) |-> mesh_done && !mesh_valid)
    else $error("lone edge status outside mesh end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) && $stable(mesh_done))
    else $error("stalled result changed");

endmodule

bind mesh_edge_pairing_check mepc_port_checks u_mepc_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .status     (status),
  .mesh_done  (mesh_done),
  .mesh_valid (mesh_valid)
);
`default_nettype wire
